// ===== rtl/signed_int_to_decimal_ascii_macros.svh =====
// assertion macros for the signed integer to decimal text converter
// used by the rtl files that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SITD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// cause in this cycle, effect in the next one
`define SITD_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

// ===== rtl/sitd_pkg.sv =====
// shared constants and helpers for the signed integer to decimal text converter
// no dependencies
`default_nettype none

package sitd_pkg;

  // width of the two's complement input value
  localparam int unsigned VALUE_W = 32;

  // decimal digits needed for the largest magnitude, 2^(VALUE_W-1)
  function automatic int unsigned dec_digits(int unsigned w);
    logic [63:0] v;
    int unsigned n;
    v = 64'd1 << (w - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 64'd0) begin
        n++;
        v = v / 10;
      end
    end
    return n;
  endfunction

  localparam int unsigned NUM_DIG   = dec_digits(VALUE_W);
  localparam int unsigned BCD_W     = 4 * NUM_DIG;
  localparam int unsigned CNT_W     = $clog2(VALUE_W);
  localparam int unsigned DIG_CNT_W = $clog2(NUM_DIG + 1);

  // character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

endpackage

`default_nettype wire

// ===== rtl/sitd_in_if.sv =====
// input channel: one signed value per transfer
// depends on sitd_pkg
`default_nettype none

interface sitd_in_if import sitd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/sitd_out_if.sv =====
// output channel: one ascii character per transfer, last one of a number flagged
// no dependencies
`default_nettype none

interface sitd_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/sitd_bcd_step.sv =====
// one double-dabble step: add-3 correction on each bcd digit of 5 or more, then shift in one binary bit
// depends on sitd_pkg
`default_nettype none

module sitd_bcd_step import sitd_pkg::*; (
  input  wire logic [BCD_W-1:0] bcd_i,
  input  wire logic             bit_i,
  output logic      [BCD_W-1:0] bcd_o
);

  logic [BCD_W-1:0] adj;

  // digits of 5 and above get 3 added so the shift carries correctly
  always_comb begin
    for (int k = 0; k < NUM_DIG; k++) begin
      if (bcd_i[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_i[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_i[4*k +: 4];
      end
    end
  end

  // shift left by one with the next magnitude bit
  assign bcd_o = {adj[BCD_W-2:0], bit_i};

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// signed integer to decimal ascii text, top level
// depends on sitd_pkg, sitd_in_if, sitd_out_if, sitd_bcd_step and the assertion macros
//
//   channel  | dir | payload                 | per item
//   in_i     | in  | value (32b signed)      | one transfer
//   out_o    | out | ascii_char, last_char   | 1 to 11 transfers
//
// an item runs through the 32 double-dabble steps of the shared bcd adjust/shift unit, then
// one leading-zero skip or digit shift per cycle, then the optional minus sign and the digits;
// output stalls hold the sign and digit states; the output register lets the final character
// wait while the next value is taken in
// reset clears the sequencer and the output valid only
`default_nettype none

`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii import sitd_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  sitd_in_if.sink     in_i,
  sitd_out_if.source  out_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0] dig_left_q, dig_left_d;
  logic                 out_valid_q, out_valid_d;

  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic                 neg_q, neg_d;
  logic [7:0]           out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;

  logic [BCD_W-1:0]     bcd_step;
  logic [3:0]           top_dig;
  logic                 in_xfer;
  logic                 out_free;

  // shared conversion unit
  sitd_bcd_step u_step (
    .bcd_i (bcd_q),
    .bit_i (mag_q[VALUE_W-1]),
    .bcd_o (bcd_step)
  );

  assign top_dig  = bcd_q[BCD_W-1 -: 4];
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // handshake outputs
  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.ascii_char = out_char_q;
  assign out_o.last_char  = out_last_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    dig_left_d  = dig_left_q;
    out_valid_d = out_valid_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    neg_d       = neg_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    // output register drains on transfer
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          neg_d     = in_i.value[VALUE_W-1];
          mag_d     = in_i.value[VALUE_W-1] ? (~in_i.value + VALUE_W'(1)) : in_i.value;
          bcd_d     = '0;
          bit_cnt_d = CNT_W'(VALUE_W - 1);
          state_d   = S_CONV;
        end
      end
      S_CONV: begin
        bcd_d = bcd_step;
        mag_d = {mag_q[VALUE_W-2:0], 1'b0};
        if (bit_cnt_q == '0) begin
          dig_left_d = DIG_CNT_W'(NUM_DIG);
          state_d    = S_SKIP;
        end else begin
          bit_cnt_d = bit_cnt_q - CNT_W'(1);
        end
      end
      S_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if (top_dig == 4'd0 && dig_left_q > DIG_CNT_W'(1)) begin
          bcd_d      = {bcd_q[BCD_W-5:0], 4'd0};
          dig_left_d = dig_left_q - DIG_CNT_W'(1);
        end else if (neg_q) begin
          state_d = S_SIGN;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_ZERO + {4'd0, top_dig};
          out_last_d  = (dig_left_q == DIG_CNT_W'(1));
          bcd_d       = {bcd_q[BCD_W-5:0], 4'd0};
          dig_left_d  = dig_left_q - DIG_CNT_W'(1);
          if (dig_left_q == DIG_CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bit_cnt_q   <= '0;
      dig_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_left_q  <= dig_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // checks
  `SITD_ASSERT_NEXT(a_accept_starts_conv, in_xfer, state_q == S_CONV)
  `SITD_ASSERT(a_pending_char_not_done,
    (out_valid_q && !out_last_q) |-> (state_q == S_SIGN || state_q == S_EMIT))
  `SITD_ASSERT(a_char_code_legal, out_valid_q |-> (out_char_q == CHAR_MINUS ||
    (out_char_q >= CHAR_ZERO && out_char_q <= CHAR_NINE)))
  `SITD_ASSERT(a_emit_has_digits, (state_q == S_EMIT) |-> (dig_left_q != '0))

endmodule

`default_nettype wire

// ===== verif/signed_int_to_decimal_ascii_tb.sv =====
// testbench for the signed integer to decimal ascii converter: directed edge values,
// random values and a long output backlog, each character checked against a local predictor
// depends on sitd_pkg, sitd_in_if, sitd_out_if and signed_int_to_decimal_ascii
`timescale 1ns / 100ps
`default_nettype none

module signed_int_to_decimal_ascii_tb import sitd_pkg::*; ();

  localparam int unsigned RADIX        = 10;
  localparam int          MAX_IDLE     = 11;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          BACKLOG_HOLD = 300;
  localparam int          REPORT_MAX   = 10;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } text_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sitd_in_if  in_if ();
  sitd_out_if out_if ();

  signed_int_to_decimal_ascii u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  text_char_t expected_chars [$];
  int         miss_cnt    = 0;
  int         idle_cycles = 0;
  int         hold_len    = 0;
  bit         src_idle    = 1'b0;
  bit         snk_idle    = 1'b0;

  always #10 clk_i = ~clk_i;

  // decimal text of one value: optional minus sign, digits most significant first
  function automatic void predict_text(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    logic [7:0]         digit_chars [0:19];
    int                 n;
    mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    n = 0;
    do begin
      digit_chars[n] = CHAR_ZERO + 8'(mag % RADIX);
      mag = mag / RADIX;
      n++;
    end while (mag != 0);
    if (raw[VALUE_W-1])
      expected_chars.push_back(text_char_t'{CHAR_MINUS, 1'b0});
    for (int i = n - 1; i >= 0; i--)
      expected_chars.push_back(text_char_t'{digit_chars[i], (i == 0)});
  endfunction

  // random value, biased toward every digit count, powers of ten and the range ends
  function automatic logic [VALUE_W-1:0] draw_value();
    longint unsigned lo, hi, r;
    int              nd;
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1, 2: begin
        nd = $urandom_range(1, 10);
        lo = 1;
        repeat (nd - 1) lo = lo * RADIX;
        hi = lo * RADIX - 1;
        if (nd == 1) lo = 0;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        r = {$urandom, $urandom};
        v = VALUE_W'(lo + r % (hi - lo + 1));
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        lo = 1;
        repeat ($urandom_range(0, 9)) lo = lo * RADIX;
        v = VALUE_W'(lo + $urandom_range(0, 2) - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        if ($urandom_range(0, 1)) v = {1'b1, {(VALUE_W-1){1'b0}}} + $urandom_range(0, 3);
        else v = {1'b0, {(VALUE_W-1){1'b1}}} - $urandom_range(0, 3);
      end
    endcase
    return v;
  endfunction

  // one input transfer, after a random gap when source idling is on
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // extremes, zero, single digits, digit count boundaries, alternating bits
  task automatic test_edge_values();
    logic [VALUE_W-1:0] edge_vals [$];
    edge_vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                  -32'sd9, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                  -32'sd999999999, 32'd123456789, -32'sd1000000000, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'd1999999999, 32'hFFFF_0000, 32'h0000_FFFF};
    src_idle = 1'b0;
    snk_idle = 1'b0;
    foreach (edge_vals[i]) send_value(edge_vals[i]);
  endtask

  // random values: a stretch without idling, both sides idling, then only the sink idling
  task automatic test_random_values();
    for (int i = 0; i < 230; i++) begin
      src_idle = (i >= 40) && (i < 190);
      snk_idle = (i >= 40);
      send_value(draw_value());
    end
  endtask

  // sink holds off for a long stretch while values keep coming back to back
  task automatic test_output_backlog();
    src_idle = 1'b0;
    snk_idle = 1'b1;
    hold_len = BACKLOG_HOLD;
    for (int i = 0; i < 20; i++) send_value(draw_value());
  endtask

  // sink side: random gaps per character, plus the requested long hold-off
  initial begin : char_sink
    int gap;
    out_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_len > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      gap = snk_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // expected text for every accepted value
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) predict_text(in_if.value);
  end

  // compare each character transfer with the oldest expected one
  always @(posedge clk_i) begin : char_check
    text_char_t exp_c;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_chars.size() == 0) begin
        miss_cnt++;
        if (miss_cnt <= REPORT_MAX)
          $display("%0t: unexpected character %h last %b", $time,
                   out_if.ascii_char, out_if.last_char);
      end else begin
        exp_c = expected_chars.pop_front();
        if (exp_c.ascii_char !== out_if.ascii_char || exp_c.last_char !== out_if.last_char) begin
          miss_cnt++;
          if (miss_cnt <= REPORT_MAX)
            $display("%0t: character expected %h last %b, got %h last %b", $time,
                     exp_c.ascii_char, exp_c.last_char, out_if.ascii_char, out_if.last_char);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("signed_int_to_decimal_ascii: mismatch");
      $finish;
    end
  end

  // reset, test sequence, drain and verdict
  initial begin
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_values();
    test_random_values();
    test_output_backlog();
    in_if.valid <= 1'b0;
    // let the final transfer reach the expected queue before the queue is checked
    @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (miss_cnt == 0 && expected_chars.size() == 0)
      $display("signed_int_to_decimal_ascii: match");
    else
      $display("signed_int_to_decimal_ascii: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
